// ----- src/dhss_pkg.sv -----
// Package for the double-hash string set: constants, codes and types.
// Used by double_hash_string_set_top and the testbench; depends on nothing else.
package dhss_pkg;

  localparam int unsigned DefMaxCapacity = 1024;
  localparam int unsigned DefInitCapacity = 8;
  localparam int unsigned DefMaxKeyLen = 8;

  localparam logic [1:0] OpQuery = 2'd0;
  localparam logic [1:0] OpAdd = 2'd1;
  localparam logic [1:0] OpDelete = 2'd2;
  localparam logic [1:0] OpInvalid = 2'd3;

  localparam logic [1:0] TagEmpty = 2'd0;
  localparam logic [1:0] TagLive = 2'd1;
  localparam logic [1:0] TagTomb = 2'd2;

  localparam logic [1:0] StatFail = 2'd0;
  localparam logic [1:0] StatOk = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  localparam logic [63:0] Factor1 = 64'd71;
  localparam logic [63:0] Factor2 = 64'd131;

  // One slot as stored in memory.
  typedef struct packed {
    logic [1:0]  tag;
    logic [3:0]  len;
    logic [63:0] key;
  } slot_t;

endpackage

// ----- src/double_hash_string_set_top.sv -----
// Double-hash string set: a sequencer around one slot memory with two banks.
// Depends on dhss_pkg.
//
// Each item is handled one at a time. Hashing does one 64-bit multiply-add
// per hash for each key byte and then loads the first probe position, and
// probing then visits one slot at a time: each probe is a registered read
// of the slot memory, followed by a decision. The next item can be taken
// in the same cycle in which the result appears. The result waits in its own
// output register, so a stalled result only holds back the next result.
// An add that triggers growth first clears the new bank and then rehashes
// every old slot: a slot that is not live is read and checked, and each
// live key is hashed anew and placed by probes of the new bank, each a read
// followed by a placement check.
// After reset the tags of both banks are cleared, and no item is accepted
// until that sweep is done.
module double_hash_string_set_top
  import dhss_pkg::*;
#(
  parameter int unsigned MaxCapacity = DefMaxCapacity,
  parameter int unsigned InitCapacity = DefInitCapacity,
  parameter int unsigned MaxKeyLen = DefMaxKeyLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  key_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o
);

  localparam int unsigned CapW = $clog2(MaxCapacity);
  localparam int unsigned AddrW = CapW + 1;
  localparam int unsigned CntW = CapW + 1;
  localparam int unsigned NSlots = 2 * MaxCapacity;
  localparam logic [3:0] MaxLen4 = 4'(MaxKeyLen);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StHash = 4'd2;
  localparam logic [3:0] StRead = 4'd3;
  localparam logic [3:0] StDecide = 4'd4;
  localparam logic [3:0] StGrowClr = 4'd5;
  localparam logic [3:0] StGrowRd = 4'd6;
  localparam logic [3:0] StGrowChk = 4'd7;
  localparam logic [3:0] StGrowHash = 4'd8;
  localparam logic [3:0] StGrowProbe = 4'd9;
  localparam logic [3:0] StGrowPlace = 4'd10;
  localparam logic [3:0] StDone = 4'd11;

  slot_t mem_q [NSlots];
  slot_t rd_q;
  logic  we;
  logic [AddrW-1:0] waddr, raddr;
  logic  re;
  slot_t wdata;

  logic [3:0] st_q, st_d;
  logic bank_q;
  logic [CntW-1:0] cap_q, live_q, idx_q, probe_q, src_q;
  logic [AddrW-1:0] tomb_q;
  logic have_tomb_q;
  logic [1:0] op_q;
  logic [63:0] key_q, h1_q, h2_q;
  logic [3:0] len_q, byte_q;
  logic [1:0] status_q;
  logic [1:0] out_status_q;
  logic out_valid_q;
  logic [CapW-1:0] pos_q;

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  logic [CapW-1:0] cap_mask;
  logic [CapW-1:0] cap_mask2;
  assign cap_mask = CapW'(cap_q - 1'b1);
  assign cap_mask2 = CapW'((cap_q << 1) - 1'b1);

  logic [63:0] mkey;
  logic [3:0] slen;
  always_comb begin
    slen = (key_length_i > MaxLen4) ? MaxLen4 : key_length_i;
    mkey = key_bytes_i;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= slen) mkey[b*8 +: 8] = 8'd0;
    end
  end

  logic [7:0] cur_byte;
  assign cur_byte = key_q[{byte_q[2:0], 3'b000} +: 8];

  logic [63:0] step;
  assign step = {h2_q[62:0], 1'b1};

  logic [AddrW-1:0] cur_addr;
  assign cur_addr = {bank_q, pos_q & cap_mask};
  logic [AddrW-1:0] new_addr;
  assign new_addr = {~bank_q, pos_q & cap_mask2};

  logic accept;
  assign accept = (st_q == StIdle) && in_valid_i;
  assign in_stall_o = (st_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;

  logic need_grow;
  assign need_grow = ({live_q, 2'b00} >= ({1'b0, cap_q, 1'b0} + {2'b00, cap_q}))
                     && ((cap_q << 1) <= CntW'(MaxCapacity))
                     && (cap_q != CntW'(MaxCapacity));

  logic key_eq;
  assign key_eq = (rd_q.key == key_q) && (rd_q.len == len_q);

  always_comb begin
    st_d = st_q;
    we = 1'b0;
    waddr = cur_addr;
    wdata = '{tag: TagLive, len: len_q, key: key_q};
    re = 1'b0;
    raddr = cur_addr;
    unique case (st_q)
      StClear: begin
        we = 1'b1;
        waddr = idx_q[AddrW-1:0];
        wdata = '{tag: TagEmpty, len: 4'd0, key: 64'd0};
        if (idx_q == CntW'(NSlots - 1)) st_d = StIdle;
      end
      StIdle: if (accept) begin
        if (op_i == OpInvalid) st_d = StDone;
        else if (op_i == OpAdd && need_grow) st_d = StGrowClr;
        else st_d = StHash;
      end
      StHash: if (byte_q == len_q) st_d = StRead;
      StRead: begin
        re = 1'b1;
        st_d = StDecide;
      end
      StDecide: st_d = StRead;
      StGrowClr: begin
        we = 1'b1;
        waddr = {~bank_q, idx_q[CapW-1:0]};
        wdata = '{tag: TagEmpty, len: 4'd0, key: 64'd0};
        if (idx_q == CntW'((cap_q << 1) - 1'b1)) st_d = StGrowRd;
      end
      StGrowRd: begin
        re = 1'b1;
        raddr = {bank_q, src_q[CapW-1:0]};
        st_d = StGrowChk;
      end
      StGrowChk: st_d = StGrowHash;
      StGrowHash: if (byte_q == len_q) st_d = StGrowProbe;
      StGrowProbe: begin
        re = 1'b1;
        raddr = new_addr;
        st_d = StGrowPlace;
      end
      StGrowPlace: st_d = StGrowProbe;
      StDone: if (!out_valid_q || !out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
    // Decisions that depend on read data.
    if (st_q == StDecide) begin
      if (rd_q.tag == TagEmpty) begin
        st_d = StDone;
        if (op_q == OpAdd) we = 1'b1;
      end else if (rd_q.tag == TagLive && key_eq) begin
        st_d = StDone;
        if (op_q == OpDelete) begin
          we = 1'b1;
          wdata = '{tag: TagTomb, len: len_q, key: key_q};
        end
      end else if (probe_q == cap_q - 1'b1) begin
        st_d = StDone;
        if (op_q == OpAdd && (have_tomb_q || rd_q.tag == TagTomb)) begin
          we = 1'b1;
          waddr = have_tomb_q ? tomb_q : cur_addr;
        end
      end
    end
    if (st_q == StGrowChk) begin
      if (rd_q.tag != TagLive) begin
        st_d = (src_q == cap_q - 1'b1) ? StHash : StGrowRd;
      end
    end
    if (st_q == StGrowPlace && rd_q.tag == TagEmpty) begin
      we = 1'b1;
      waddr = new_addr;
      wdata = '{tag: TagLive, len: len_q, key: key_q};
      st_d = (src_q == cap_q - 1'b1) ? StHash : StGrowRd;
    end
  end

  logic [63:0] key_in_q;
  logic [3:0] len_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      bank_q <= 1'b0;
      cap_q <= CntW'(InitCapacity);
      live_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StDone && st_d == StIdle) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        StClear: idx_q <= idx_q + 1'b1;
        StIdle: idx_q <= '0;
        StGrowClr: idx_q <= idx_q + 1'b1;
        default: ;
      endcase
      if (st_q == StDecide && we && op_q == OpAdd) live_q <= live_q + 1'b1;
      if (st_q == StDecide && we && op_q == OpDelete) live_q <= live_q - 1'b1;
      // Growth ends: switch to the new bank.
      if ((st_q == StGrowChk || st_q == StGrowPlace) && st_d == StHash) begin
        bank_q <= ~bank_q;
        cap_q <= cap_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StDone && st_d == StIdle) out_status_q <= status_q;
    if (accept) begin
      op_q <= op_i;
      key_q <= mkey;
      len_q <= slen;
      key_in_q <= mkey;
      len_in_q <= slen;
      byte_q <= '0;
      h1_q <= '0;
      h2_q <= '0;
      probe_q <= '0;
      src_q <= '0;
      have_tomb_q <= 1'b0;
      status_q <= StatFail;
    end
    if (st_q == StHash || st_q == StGrowHash) begin
      if (byte_q != len_q) begin
        h1_q <= h1_q * Factor1 + {56'd0, cur_byte};
        h2_q <= h2_q * Factor2 + {56'd0, cur_byte};
        byte_q <= byte_q + 1'b1;
      end else begin
        pos_q <= h1_q[CapW-1:0];
        probe_q <= '0;
      end
    end
    if (st_q == StDecide) begin
      pos_q <= pos_q + step[CapW-1:0];
      probe_q <= probe_q + 1'b1;
      if (rd_q.tag == TagTomb && !have_tomb_q) begin
        have_tomb_q <= 1'b1;
        tomb_q <= cur_addr;
      end
      if (rd_q.tag == TagEmpty) begin
        if (op_q == OpAdd) status_q <= StatOk;
      end else if (rd_q.tag == TagLive && key_eq) begin
        if (op_q != OpAdd) status_q <= StatOk;
      end else if (probe_q == cap_q - 1'b1 && op_q == OpAdd) begin
        status_q <= (have_tomb_q || rd_q.tag == TagTomb) ? StatOk : StatFull;
      end
    end
    if (st_q == StGrowChk && rd_q.tag == TagLive) begin
      key_q <= rd_q.key;
      len_q <= rd_q.len;
      byte_q <= '0;
      h1_q <= '0;
      h2_q <= '0;
    end
    if (st_q == StGrowPlace) pos_q <= pos_q + step[CapW-1:0];
    if ((st_q == StGrowChk && rd_q.tag != TagLive) || (st_q == StGrowPlace && we)) begin
      src_q <= src_q + 1'b1;
      if (st_d == StHash) begin
        key_q <= key_in_q;
        len_q <= len_in_q;
        byte_q <= '0;
        h1_q <= '0;
        h2_q <= '0;
      end
    end
  end

  // The live count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) live_q <= cap_q)
    else $error("live count above capacity");
  // No item is accepted while the tag sweep after reset runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StClear |-> in_stall_o)
    else $error("accept during clear");
  // A result appears only after the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == StDone)
    else $error("result without completion");

endmodule

// ----- tb/tb.sv -----
// Testbench for double_hash_string_set_top: random and directed set operations
// are checked against a behavioral model of the hash table. Depends on dhss_pkg.
`timescale 1ns / 1ps

module tb;
  import dhss_pkg::*;

  localparam int unsigned MaxCap = DefMaxCapacity;
  localparam int unsigned NumSlots = 2 * MaxCap;
  localparam int unsigned PoolSize = 48;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OpQuery;
  logic [63:0] key_bytes_i = '0;
  logic [3:0]  key_length_i = 4'd1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;

  double_hash_string_set_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .op_i(op_i), .key_bytes_i(key_bytes_i), .key_length_i(key_length_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o)
  );

  // Shadow copy of the table.
  logic [1:0]  shadow_tag [NumSlots];
  logic [63:0] shadow_key [NumSlots];
  logic [3:0]  shadow_len [NumSlots];
  int unsigned shadow_bank;
  int unsigned shadow_cap;
  int unsigned shadow_live;

  logic [1:0]  status_queue [$];
  logic [63:0] key_pool [PoolSize];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;

  initial forever #6 clk_i = ~clk_i;

  function automatic logic [63:0] poly_hash(logic [63:0] k, int unsigned len,
                                            logic [63:0] factor);
    logic [63:0] h;
    h = '0;
    for (int unsigned i = 0; i < len; i++) h = h * factor + k[8*i +: 8];
    return h;
  endfunction

  function automatic int unsigned slot_at(logic [63:0] h1, logic [63:0] step,
                                          int unsigned i, int unsigned cap);
    logic [63:0] p;
    p = h1 + 64'(i) * step;
    return int'(p & 64'(cap - 1));
  endfunction

  function automatic void grow_shadow();
    int unsigned old_base, new_base, new_cap, src, dst;
    logic [63:0] h1, step;
    old_base = shadow_bank * MaxCap;
    new_base = (shadow_bank ^ 1) * MaxCap;
    new_cap = shadow_cap * 2;
    for (int unsigned i = 0; i < new_cap; i++) shadow_tag[new_base + i] = TagEmpty;
    for (int unsigned i = 0; i < shadow_cap; i++) begin
      src = old_base + i;
      if (shadow_tag[src] == TagLive) begin
        h1 = poly_hash(shadow_key[src], shadow_len[src], Factor1);
        step = 1 + (poly_hash(shadow_key[src], shadow_len[src], Factor2) << 1);
        for (int unsigned j = 0; j < new_cap; j++) begin
          dst = new_base + slot_at(h1, step, j, new_cap);
          if (shadow_tag[dst] == TagEmpty) begin
            shadow_tag[dst] = TagLive;
            shadow_key[dst] = shadow_key[src];
            shadow_len[dst] = shadow_len[src];
            break;
          end
        end
      end
    end
    shadow_bank ^= 1;
    shadow_cap = new_cap;
  endfunction

  // Applies one operation to the shadow table and returns the status it yields.
  function automatic logic [1:0] apply_set_op(logic [1:0] op, logic [63:0] raw,
                                              logic [3:0] raw_len);
    int unsigned len, base, s, tomb;
    logic [63:0] k, h1, step;
    bit have_tomb;
    have_tomb = 0;
    tomb = 0;
    if (op != OpQuery && op != OpAdd && op != OpDelete) return StatFail;
    len = (raw_len > DefMaxKeyLen) ? DefMaxKeyLen : raw_len;
    k = (len >= 8) ? raw : raw & ((64'd1 << (8 * len)) - 1);
    if (op == OpAdd && shadow_live * 4 >= shadow_cap * 3 && shadow_cap * 2 <= MaxCap)
      grow_shadow();
    base = shadow_bank * MaxCap;
    h1 = poly_hash(k, len, Factor1);
    step = 1 + (poly_hash(k, len, Factor2) << 1);
    for (int unsigned i = 0; i < shadow_cap; i++) begin
      s = base + slot_at(h1, step, i, shadow_cap);
      if (shadow_tag[s] == TagEmpty) begin
        if (op != OpAdd) return StatFail;
        shadow_tag[s] = TagLive;
        shadow_key[s] = k;
        shadow_len[s] = 4'(len);
        shadow_live++;
        return StatOk;
      end else if (shadow_tag[s] == TagLive) begin
        if (shadow_key[s] == k && shadow_len[s] == 4'(len)) begin
          if (op == OpAdd) return StatFail;
          if (op == OpDelete) begin
            shadow_tag[s] = TagTomb;
            shadow_live--;
          end
          return StatOk;
        end
      end else if (!have_tomb) begin
        have_tomb = 1;
        tomb = s;
      end
    end
    if (op != OpAdd) return StatFail;
    if (!have_tomb) return StatFull;
    shadow_tag[tomb] = TagLive;
    shadow_key[tomb] = k;
    shadow_len[tomb] = 4'(len);
    shadow_live++;
    return StatOk;
  endfunction

  function automatic logic [63:0] letter_key(int unsigned len);
    logic [63:0] k;
    k = '0;
    for (int unsigned i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(97, 122));
    return k;
  endfunction

  // Valid stays high between back-to-back items; it drops only for an idle gap.
  task automatic send_item(logic [1:0] op, logic [63:0] k, logic [3:0] len);
    bit stalled;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    key_bytes_i <= k;
    key_length_i <= len;
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    status_queue.push_back(apply_set_op(op, k, len));
  endtask

  // Result side: random stall, sample at the falling edge, accept at the rising one.
  initial begin
    bit taken;
    logic [1:0] got;
    logic [1:0] want;
    forever begin
      @(negedge clk_i);
      taken = rst_ni && out_valid_o && !out_stall_i;
      got = status_o;
      @(posedge clk_i);
      if (taken) begin
        if (status_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d", $realtime, got);
          error_count++;
        end else begin
          want = status_queue.pop_front();
          if (got !== want) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $realtime, want, got);
            error_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic test_special_cases();
    send_item(OpQuery, 64'h61, 4'd1);                   // empty table
    send_item(OpAdd, 64'hDEAD_BEEF_0000_0000, 4'd0);    // empty key
    send_item(OpQuery, 64'h0, 4'd0);
    send_item(OpAdd, 64'hFFFF_FF00_0063_6261, 4'd3);    // junk past the length
    send_item(OpQuery, 64'h1234_5678_9A63_6261, 4'd3);
    send_item(OpAdd, 64'h0000_0000_0063_6261, 4'd3);    // duplicate
    send_item(OpAdd, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);   // saturated length
    send_item(OpQuery, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(OpQuery, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7);
    send_item(OpInvalid, 64'h61, 4'd1);                 // unknown operation
    send_item(OpDelete, 64'h6362_61, 4'd3);
    send_item(OpDelete, 64'h6362_61, 4'd3);
    send_item(OpQuery, 64'h6362_61, 4'd3);
    send_item(OpAdd, 64'h0102_0304_0506_0708, 4'd8);    // non-letter bytes
    for (int i = 0; i < 9; i++) send_item(OpAdd, letter_key(1 + i % 8), 4'(1 + i % 8));
    send_item(OpAdd, 64'h6362_61, 4'd3);
    send_item(OpQuery, 64'h0102_0304_0506_0708, 4'd8);
  endtask

  task automatic test_random_ops(int unsigned count);
    int unsigned pick;
    logic [1:0] op;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        op = (pick < 35) ? OpQuery : (pick < 65) ? OpAdd : OpDelete;
        pick = $urandom_range(PoolSize - 1);
        send_item(op, key_pool[pick], 4'(1 + pick % 8));
      end else begin
        send_item(2'($urandom), {$urandom, $urandom}, 4'($urandom));
      end
    end
  endtask

  // Fills the table to its maximum size, then frees a few slots and reuses them.
  task automatic test_full_table();
    logic [63:0] k;
    for (int unsigned i = 0; i < 1100; i++) begin
      k = {40'd0, 8'(97 + i / 676), 8'(97 + (i / 26) % 26), 8'(97 + i % 26)};
      send_item(OpAdd, k, 4'd3);
    end
    for (int unsigned i = 0; i < 10; i++)
      send_item(OpDelete, {40'd0, 8'h61, 8'h61, 8'(97 + i)}, 4'd3);
    for (int unsigned i = 0; i < 12; i++) send_item(OpAdd, letter_key(6), 4'd6);
    send_item(OpQuery, 64'h6261_61, 4'd3);
  endtask

  task automatic set_idling(int unsigned snd, int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  initial begin
    int unsigned waited;
    error_count = 0;
    shadow_bank = 0;
    shadow_cap = DefInitCapacity;
    shadow_live = 0;
    for (int unsigned i = 0; i < NumSlots; i++) shadow_tag[i] = TagEmpty;
    for (int unsigned i = 0; i < PoolSize; i++) key_pool[i] = letter_key(1 + i % 8);
    set_idling(35, 49);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_special_cases();
    test_random_ops(220);
    set_idling(49, 35);
    test_random_ops(220);
    set_idling(0, 0);
    test_random_ops(220);
    test_full_table();
    in_valid_i <= 1'b0;
    waited = 0;
    while (status_queue.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (status_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, status_queue.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
